>>> hdl/button_press_mode_selector_macros.svh
// ----------------------------------------------------------------------------
// button press mode selector assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_MODE_SELECTOR_MACROS_SVH
`define BUTTON_PRESS_MODE_SELECTOR_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BPMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BPMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPMS_ASSERT_NOW(lbl, ante, cons, msg)
`define BPMS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/bpms_pkg.sv
// ----------------------------------------------------------------------------
// bpms_pkg
// types, codes and helpers of the button press mode selector
// ----------------------------------------------------------------------------
package bpms_pkg;

  // press machine states
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DEBOUNCE = 2'd1;
  localparam logic [1:0] ST_PRESSED  = 2'd2;

  // press event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // charge mode selected by a long press
  localparam logic [2:0] MODE_LONG = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS = 2'd1;

  // configuration reset values
  localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;

  // one poll word
  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_down;
  } bpms_item_t;

  // one result word
  typedef struct packed {
    logic [1:0] press_event;
    logic [2:0] charge_mode;
    logic       store_write;
  } bpms_result_t;

  // short press mode step: long mode back to 0, else cycle 0..3
  function automatic logic [2:0] next_mode(input logic [2:0] m);
    logic [2:0] r;
    if (m == MODE_LONG) begin
      r = 3'd0;
    end else begin
      r = {1'b0, m[1:0] + 2'd1};
    end
    return r;
  endfunction

endpackage

>>> hdl/button_press_mode_selector.sv
// a poll waits in the input register, then its result word goes to the result
// register; one poll word per cycle is taken while out_stall is low; the press
// state updates once per poll as the word leaves the input register for the
// result register; a stalled result register holds back the input register,
// which then stalls; reset: synchronous, active low; clears the press machine,
// mode to 0 and loads debounce 20 ms and long press 2000 ms
// ----------------------------------------------------------------------------
// button_press_mode_selector
// debounced short and long press detection stepping a charge mode
// ----------------------------------------------------------------------------
`include "button_press_mode_selector_macros.svh"

module button_press_mode_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_now_ms,
  input  logic        in_button_down,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_press_event,
  output logic [2:0]  out_charge_mode,
  output logic        out_store_write
);
  import bpms_pkg::*;

  bpms_item_t   in_item;
  bpms_item_t   s1_item;
  logic         s1_valid;
  logic         out_free;
  logic         adv;
  bpms_result_t core_res;
  bpms_result_t out_res;

  assign in_item.now_ms      = in_now_ms;
  assign in_item.button_down = in_button_down;

  // held poll moves into the result register when there is room
  assign adv = s1_valid && out_free;

  bpms_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .adv      (adv),
    .in_stall (in_stall),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  bpms_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .item      (s1_item),
    .upd       (adv),
    .result    (core_res)
  );

  bpms_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res_in    (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (out_free),
    .res_out   (out_res)
  );

  assign out_press_event = out_res.press_event;
  assign out_charge_mode = out_res.charge_mode;
  assign out_store_write = out_res.store_write;

  // checks
  `BPMS_ASSERT_NOW(a_store_on_event, out_valid, out_store_write == (out_press_event != EV_NONE), "store strobe does not match event")
  `BPMS_ASSERT_NOW(a_long_mode, out_valid && out_press_event == EV_LONG, out_charge_mode == MODE_LONG, "long press without long mode")
  `BPMS_ASSERT_NOW(a_mode_range, out_valid, out_charge_mode <= MODE_LONG, "charge mode out of range")
  `BPMS_ASSERT_NEXT(a_stall_holds, in_stall, s1_valid, "input stage emptied while stalled")

endmodule

>>> hdl/bpms_in_reg.sv
// ----------------------------------------------------------------------------
// bpms_in_reg
// input register holding one poll word ahead of the press logic
// ----------------------------------------------------------------------------
module bpms_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  bpms_pkg::bpms_item_t in_item,
  input  logic                adv,
  output logic                in_stall,
  output logic                s1_valid,
  output bpms_pkg::bpms_item_t s1_item
);
  import bpms_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  bpms_item_t item_r;
  logic       take;

  // take a word when empty or when the held word moves on
  assign in_stall = valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

>>> hdl/bpms_core.sv
// ----------------------------------------------------------------------------
// bpms_core
// press state machine, mode register and configuration registers
// ----------------------------------------------------------------------------
module bpms_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [15:0]           cfg_wdata,
  input  bpms_pkg::bpms_item_t  item,
  input  logic                  upd,
  output bpms_pkg::bpms_result_t result
);
  import bpms_pkg::*;

  logic [15:0] debounce_r;
  logic [15:0] long_press_r;
  logic [1:0]  state_r;
  logic [1:0]  state_nxt;
  logic [31:0] start_r;
  logic [31:0] start_nxt;
  logic        long_done_r;
  logic        long_done_nxt;
  logic [2:0]  mode_r;
  logic [2:0]  mode_nxt;
  logic [1:0]  event_nxt;
  logic [31:0] elapsed;
  logic        deb_met;
  logic        long_met;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // wrapping hold time and threshold checks
  assign elapsed  = item.now_ms - start_r;
  assign deb_met  = elapsed >= {16'd0, debounce_r};
  assign long_met = elapsed >= {16'd0, long_press_r};

  // next state for this poll
  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    long_done_nxt = long_done_r;
    mode_nxt      = mode_r;
    event_nxt     = EV_NONE;
    if (item.button_down) begin
      if (!long_done_r) begin
        unique case (state_r)
          ST_IDLE: begin
            state_nxt = ST_DEBOUNCE;
            start_nxt = item.now_ms;
          end
          ST_DEBOUNCE: begin
            if (deb_met) begin
              state_nxt = ST_PRESSED;
            end
          end
          ST_PRESSED: begin
            if (long_met) begin
              mode_nxt      = MODE_LONG;
              long_done_nxt = 1'b1;
              state_nxt     = ST_IDLE;
              start_nxt     = 32'd0;
              event_nxt     = EV_LONG;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
    end else begin
      // release ends every hold
      if (state_r == ST_PRESSED && !long_done_r) begin
        mode_nxt  = next_mode(mode_r);
        event_nxt = EV_SHORT;
      end
      state_nxt     = ST_IDLE;
      long_done_nxt = 1'b0;
    end
  end

  // state registers, advanced once per poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 32'd0;
      long_done_r <= 1'b0;
      mode_r      <= 3'd0;
    end else if (upd) begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      long_done_r <= long_done_nxt;
      mode_r      <= mode_nxt;
    end
  end

  assign result.press_event = event_nxt;
  assign result.charge_mode = mode_nxt;
  assign result.store_write = (event_nxt != EV_NONE);

endmodule

>>> hdl/bpms_out_reg.sv
// ----------------------------------------------------------------------------
// bpms_out_reg
// result register toward the output channel
// ----------------------------------------------------------------------------
module bpms_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  bpms_pkg::bpms_result_t res_in,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   free,
  output bpms_pkg::bpms_result_t res_out
);
  import bpms_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  bpms_result_t res_r;

  // room for a new word when empty or when the held word leaves now
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule
